// ----- rtl/rhc_pkg.sv -----
// Shared types and constants for the RGB/HSL color converter.
// No dependencies; used by rhc_half_div and rgb_hsl_color_converter.
package rhc_pkg;

  typedef enum logic {
    CMD_RGB2HSL = 1'b0,
    CMD_HSL2RGB = 1'b1
  } rhc_cmd_t;

  // Reciprocal multiply shifts and constants
  localparam int unsigned HALF_DIV_SHIFT = 24;
  localparam int unsigned LIGHT_SHIFT    = 23;
  localparam logic [15:0] LIGHT_RECIP    = 16'(((32'd1 << 23) + 32'd251) / 32'd252);
  localparam int unsigned SIX_SHIFT      = 46;
  localparam logic [27:0] SIX_RECIP      =
    28'(((64'd1 << 46) + 64'd399999) / 64'd400000);

endpackage

// ----- rtl/rhc_half_div.sv -----
// Exact quotient floor(num / (2 * half)) by a constant reciprocal table.
// Depends on rhc_pkg.
module rhc_half_div (
  input  logic [15:0] num,
  input  logic [5:0]  half,
  output logic [8:0]  quot
);
  import rhc_pkg::*;

  logic [23:0] recip_tab [64];
  logic [39:0] prod;

  assign recip_tab[0] = '0;
  for (genvar g = 1; g < 64; g++) begin : gen_recip
    localparam logic [23:0] Recip = 24'(((1 << 24) + 2 * g - 1) / (2 * g));
    assign recip_tab[g] = Recip;
  end

  // ceil-reciprocal is exact for 16-bit numerators and divisors below 128
  assign prod = 40'(num) * 40'(recip_tab[half]);
  assign quot = prod[HALF_DIV_SHIFT +: 9];

endmodule

// ----- rtl/rgb_hsl_color_converter.sv -----
// Top level of the RGB/HSL color converter: three-stage pipeline.
// Depends on rhc_pkg and rhc_half_div.
//
// Converts one color per transaction. With in_command = 0 it takes 6-bit red,
// green and blue and returns hue (0..359 degrees), saturation and lightness
// (0..100), each rounded half up; with in_command = 1 it takes hue, saturation
// and lightness and returns 6-bit red, green and blue. The fields that are not
// converted are echoed unchanged. An accepted transaction passes through the
// stage 1, 2 and 3 registers to out_valid; a new one is taken every cycle
// while in_stall is low. Each stage advances when its successor has room, so
// an empty stage absorbs a stalled output and no transaction is lost or
// repeated. Stage 1 finds max/min/chroma and the HSL span and chroma product,
// stage 2 does the reciprocal divides and the HSL channel sums, stage 3 wraps
// the hue, scales RGB to six bits and holds the result on the output ports.
module rgb_hsl_color_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [5:0] in_red,
  input  logic [5:0] in_green,
  input  logic [5:0] in_blue,
  input  logic [8:0] in_hue,
  input  logic [6:0] in_saturation,
  input  logic [6:0] in_lightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_red,
  output logic [5:0] out_green,
  output logic [5:0] out_blue,
  output logic [8:0] out_hue,
  output logic [6:0] out_saturation,
  output logic [6:0] out_lightness
);
  import rhc_pkg::*;

  // Round a channel held in 1/1200000 units to six bits: (21v + 200000) / 400000
  function automatic logic [5:0] to_six(input logic [20:0] v);
    logic [25:0] n;
    logic [53:0] p;
    n = 26'd21 * 26'(v) + 26'd200000;
    p = 54'(n) * 54'(SIX_RECIP);
    return p[SIX_SHIFT +: 6];
  endfunction

  // Stage enables: a stage loads when it is empty or its successor loads
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // ---------------- stage 1 ----------------
  logic [5:0]  hi, lo, chroma, den;
  logic [6:0]  sum;
  logic [15:0] hue_num;
  logic [15:0] hnum_nxt, snum_nxt;
  logic [14:0] lnum_nxt;
  logic        szero_nxt;
  logic [8:0]  hh;
  logic [6:0]  ss, ll_nxt;
  logic [7:0]  span;
  logic [13:0] cc_nxt;
  logic [6:0]  hm;
  logic [5:0]  t_nxt;
  logic [2:0]  sector_nxt;

  always_comb begin
    hi = in_red;
    if (in_green > hi) hi = in_green;
    if (in_blue > hi) hi = in_blue;
    lo = in_red;
    if (in_green < lo) lo = in_green;
    if (in_blue < lo) lo = in_blue;
    chroma = hi - lo;
    sum    = 7'(hi) + 7'(lo);

    // Ties go to red first, then green
    if (hi == in_red) begin
      if (in_green >= in_blue) begin
        hue_num = 16'd60 * (16'(in_green) - 16'(in_blue));
      end else begin
        hue_num = 16'd360 * 16'(chroma) - 16'd60 * (16'(in_blue) - 16'(in_green));
      end
    end else if (hi == in_green) begin
      hue_num = 16'd120 * 16'(chroma) + 16'd60 * 16'(in_blue) - 16'd60 * 16'(in_red);
    end else begin
      hue_num = 16'd240 * 16'(chroma) + 16'd60 * 16'(in_red) - 16'd60 * 16'(in_green);
    end
    hnum_nxt = {hue_num[14:0], 1'b0} + 16'(chroma);

    // Gray and anything at or past white have no saturation
    szero_nxt = (chroma == 6'd0) || (sum >= 7'd126);
    den       = (sum <= 7'd63) ? sum[5:0] : 6'(7'd126 - sum);
    snum_nxt  = 16'd200 * 16'(chroma) + 16'(den);
    lnum_nxt  = 15'd200 * 15'(sum) + 15'd126;

    // HSL side: wrap hue, clamp percentages
    hh     = (in_hue >= 9'd360) ? in_hue - 9'd360 : in_hue;
    ss     = (in_saturation > 7'd100) ? 7'd100 : in_saturation;
    ll_nxt = (in_lightness > 7'd100) ? 7'd100 : in_lightness;
    span   = (ll_nxt <= 7'd50) ? {ll_nxt, 1'b0} : 8'd200 - {ll_nxt, 1'b0};
    cc_nxt = 14'(16'(span) * 16'(ss));
    if (hh >= 9'd240)      hm = 7'(hh - 9'd240);
    else if (hh >= 9'd120) hm = 7'(hh - 9'd120);
    else                   hm = 7'(hh);
    t_nxt = (hm >= 7'd60) ? 6'(7'd120 - hm) : 6'(hm);
    if (hh >= 9'd300)      sector_nxt = 3'd5;
    else if (hh >= 9'd240) sector_nxt = 3'd4;
    else if (hh >= 9'd180) sector_nxt = 3'd3;
    else if (hh >= 9'd120) sector_nxt = 3'd2;
    else if (hh >= 9'd60)  sector_nxt = 3'd1;
    else                   sector_nxt = 3'd0;
  end

  rhc_cmd_t    cmd1_r;
  logic [5:0]  r1_r, g1_r, b1_r, c1_r, den1_r;
  logic [8:0]  h1_r;
  logic [6:0]  s1_r, l1_r, ll1_r;
  logic [15:0] hnum1_r, snum1_r;
  logic [14:0] lnum1_r;
  logic        szero1_r;
  logic [13:0] cc1_r;
  logic [5:0]  t1_r;
  logic [2:0]  sector1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      cmd1_r    <= rhc_cmd_t'(in_command);
      r1_r      <= in_red;
      g1_r      <= in_green;
      b1_r      <= in_blue;
      h1_r      <= in_hue;
      s1_r      <= in_saturation;
      l1_r      <= in_lightness;
      c1_r      <= chroma;
      den1_r    <= den;
      hnum1_r   <= hnum_nxt;
      snum1_r   <= snum_nxt;
      lnum1_r   <= lnum_nxt;
      szero1_r  <= szero_nxt;
      ll1_r     <= ll_nxt;
      cc1_r     <= cc_nxt;
      t1_r      <= t_nxt;
      sector1_r <= sector_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  logic [8:0]  hq, sq;
  logic [30:0] lprod;
  logic [8:0]  hue2_nxt;
  logic [6:0]  sat2_nxt, lgt2_nxt;
  logic [14:0] l200;
  logic [20:0] ms, cs, xs;
  logic [20:0] vr_nxt, vg_nxt, vb_nxt;

  rhc_half_div u_hue_div (
    .num  (hnum1_r),
    .half (c1_r),
    .quot (hq)
  );

  rhc_half_div u_sat_div (
    .num  (snum1_r),
    .half (den1_r),
    .quot (sq)
  );

  always_comb begin
    hue2_nxt = (c1_r == 6'd0) ? 9'd0 : hq;
    sat2_nxt = szero1_r ? 7'd0 : sq[6:0];
    lprod    = 31'(lnum1_r) * 31'(LIGHT_RECIP);
    lgt2_nxt = lprod[LIGHT_SHIFT +: 7];

    // Channel levels in 1/1200000 units: m, X + m, C + m
    l200 = 15'd200 * 15'(ll1_r);
    ms   = 21'd60 * 21'(l200 - 15'(cc1_r));
    cs   = 21'd120 * 21'(cc1_r) + ms;
    xs   = 21'd2 * 21'(cc1_r) * 21'(t1_r) + ms;
    unique case (sector1_r)
      3'd0:    begin vr_nxt = cs; vg_nxt = xs; vb_nxt = ms; end
      3'd1:    begin vr_nxt = xs; vg_nxt = cs; vb_nxt = ms; end
      3'd2:    begin vr_nxt = ms; vg_nxt = cs; vb_nxt = xs; end
      3'd3:    begin vr_nxt = ms; vg_nxt = xs; vb_nxt = cs; end
      3'd4:    begin vr_nxt = xs; vg_nxt = ms; vb_nxt = cs; end
      default: begin vr_nxt = cs; vg_nxt = ms; vb_nxt = xs; end
    endcase
  end

  rhc_cmd_t    cmd2_r;
  logic [5:0]  r2_r, g2_r, b2_r;
  logic [8:0]  h2_r, hue2_r;
  logic [6:0]  s2_r, l2_r, sat2_r, lgt2_r;
  logic [20:0] vr2_r, vg2_r, vb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      cmd2_r <= cmd1_r;
      r2_r   <= r1_r;
      g2_r   <= g1_r;
      b2_r   <= b1_r;
      h2_r   <= h1_r;
      s2_r   <= s1_r;
      l2_r   <= l1_r;
      hue2_r <= hue2_nxt;
      sat2_r <= sat2_nxt;
      lgt2_r <= lgt2_nxt;
      vr2_r  <= vr_nxt;
      vg2_r  <= vg_nxt;
      vb2_r  <= vb_nxt;
    end
  end

  // ---------------- stage 3 / output register ----------------
  logic [8:0] hue_wrap;
  logic [5:0] red_nxt, green_nxt, blue_nxt;
  logic [8:0] hue_nxt;
  logic [6:0] sat_nxt, lgt_nxt;

  always_comb begin
    // Hue that rounds up to 360 wraps to 0
    hue_wrap = (hue2_r >= 9'd360) ? hue2_r - 9'd360 : hue2_r;
    unique case (cmd2_r)
      CMD_RGB2HSL: begin
        red_nxt   = r2_r;
        green_nxt = g2_r;
        blue_nxt  = b2_r;
        hue_nxt   = hue_wrap;
        sat_nxt   = sat2_r;
        lgt_nxt   = lgt2_r;
      end
      default: begin
        red_nxt   = to_six(vr2_r);
        green_nxt = to_six(vg2_r);
        blue_nxt  = to_six(vb2_r);
        hue_nxt   = h2_r;
        sat_nxt   = s2_r;
        lgt_nxt   = l2_r;
      end
    endcase
  end

  rhc_cmd_t   cmd3_r;
  logic [5:0] red_r, green_r, blue_r;
  logic [8:0] hue_r;
  logic [6:0] sat_r, lgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      cmd3_r  <= cmd2_r;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      lgt_r   <= lgt_nxt;
    end
  end

  assign out_valid      = v3_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_lightness  = lgt_r;

  // ---------------- assertions ----------------
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline valid bits not cleared by reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r)
    else $error("input stalled while a stage has room");

  a_hsl_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && cmd3_r == CMD_RGB2HSL |-> hue_r < 9'd360 && sat_r <= 7'd100 && lgt_r <= 7'd100)
    else $error("converted HSL out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && v3_r && out_stall |=> v2_r && v3_r)
    else $error("stage contents dropped during output stall");

endmodule

// ----- dv/rgb_hsl_color_converter_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the RGB/HSL color converter: directed and random colors,
// self-checking against an in-bench integer predictor. Depends on rhc_pkg and the RTL.
module rgb_hsl_color_converter_tb;
  import rhc_pkg::*;

  typedef struct packed {
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] light;
  } color_t;

  // Round(63 * v) where v is in 1/1200000 units.
  function automatic logic [63:0] scale_six(logic [63:0] v);
    return (126 * v + 1200000) / 2400000;
  endfunction

  function automatic color_t convert_color(rhc_cmd_t cmd, color_t c);
    color_t o;
    logic [63:0] r, g, b, hi, lo, ch, sum, num, den, hv;
    logic [63:0] h, s, l, span, cc, hm, t, cs, xs, ms, sec;
    o = c;
    r = 64'(c.red); g = 64'(c.green); b = 64'(c.blue);
    if (cmd == CMD_RGB2HSL) begin
      hi = r; lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      ch = hi - lo; sum = hi + lo;
      if (ch == 0) hv = 0;
      else begin
        // ties resolve red first, then green
        if (hi == r) num = (g >= b) ? 60 * (g - b) : 360 * ch - 60 * (b - g);
        else if (hi == g) num = 120 * ch + 60 * b - 60 * r;
        else num = 240 * ch + 60 * r - 60 * g;
        hv = (2 * num + ch) / (2 * ch);
        if (hv >= 360) hv -= 360;
      end
      o.hue = hv[8:0];
      o.light = 7'((200 * sum + 126) / 252);
      if (ch == 0 || sum >= 126) o.sat = 0;
      else begin
        den = (sum <= 63) ? sum : 126 - sum;
        o.sat = 7'((200 * ch + den) / (2 * den));
      end
    end else begin
      h = 64'(c.hue) % 360; s = 64'(c.sat); l = 64'(c.light);
      if (s > 100) s = 100;
      if (l > 100) l = 100;
      span = (l <= 50) ? 2 * l : 200 - 2 * l;
      cc = span * s;
      hm = h % 120;
      t = (hm >= 60) ? 120 - hm : hm;
      ms = 60 * (200 * l - cc);
      cs = 120 * cc + ms;
      xs = 2 * cc * t + ms;
      sec = h / 60;
      r = (sec == 0 || sec == 5) ? cs : (sec == 1 || sec == 4) ? xs : ms;
      g = (sec == 1 || sec == 2) ? cs : (sec == 0 || sec == 3) ? xs : ms;
      b = (sec == 3 || sec == 4) ? cs : (sec == 2 || sec == 5) ? xs : ms;
      o.red = 6'(scale_six(r));
      o.green = 6'(scale_six(g));
      o.blue = 6'(scale_six(b));
    end
    return o;
  endfunction

  // Holds expected colors in order and compares each output transaction.
  class color_scoreboard;
    color_t pending[$];
    int     mismatches;

    function void note_input(rhc_cmd_t cmd, color_t c);
      pending.push_back(convert_color(cmd, c));
    endfunction

    function void check_output(color_t got);
      color_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_command = 0;
  logic [5:0] in_red = 0, in_green = 0, in_blue = 0;
  logic [8:0] in_hue = 0;
  logic [6:0] in_saturation = 0, in_lightness = 0;
  logic out_valid, out_stall = 0;
  logic [5:0] out_red, out_green, out_blue;
  logic [8:0] out_hue;
  logic [6:0] out_saturation, out_lightness;

  rgb_hsl_color_converter uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  color_scoreboard board = new();
  int  send_idle_pct = 0, stall_pct = 0;
  bit  hold_off = 0;
  int  quiet_cycles = 0;

  // Check every output transaction at the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_output('{out_red, out_green, out_blue, out_hue,
                           out_saturation, out_lightness});
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one color and wait for it to be taken; idle first at random.
  task automatic send_color(rhc_cmd_t cmd, color_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_red <= c.red; in_green <= c.green; in_blue <= c.blue;
    in_hue <= c.hue; in_saturation <= c.sat; in_lightness <= c.light;
    do @(posedge clk); while (in_stall);
    board.note_input(cmd, c);
  endtask

  task automatic send_random(int count);
    color_t c;
    rhc_cmd_t cmd;
    repeat (count) begin
      c = color_t'(41'({$urandom, $urandom}));
      cmd = rhc_cmd_t'($urandom_range(1));
      // mostly legal ranges, with some raw out-of-range HSL
      if ($urandom_range(9) != 0) begin
        c.hue = 9'($urandom_range(359));
        c.sat = 7'($urandom_range(100));
        c.light = 7'($urandom_range(100));
      end
      send_color(cmd, c);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    color_t d[$];
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed RGB: black, white, grays, primaries, max ties, hue near 360.
    d = '{'{0,0,0,0,0,0}, '{63,63,63,0,0,0}, '{31,31,31,0,0,0},
          '{63,0,0,0,0,0}, '{0,63,0,0,0,0}, '{0,0,63,0,0,0},
          '{63,63,0,0,0,0}, '{0,63,63,0,0,0}, '{63,0,63,0,0,0},
          '{63,0,1,0,0,0}, '{1,0,0,0,0,0}, '{62,63,1,0,0,0}};
    foreach (d[i]) send_color(CMD_RGB2HSL, d[i]);
    // Directed HSL: sector edges, extremes and out-of-range values.
    d = '{'{0,0,0,0,100,50}, '{0,0,0,60,100,50}, '{0,0,0,120,100,50},
          '{0,0,0,180,100,50}, '{0,0,0,240,100,50}, '{0,0,0,359,100,50},
          '{0,0,0,0,0,100}, '{0,0,0,0,0,0}, '{0,0,0,511,127,127},
          '{63,63,63,360,101,101}, '{0,0,0,300,50,25}};
    foreach (d[i]) send_color(CMD_HSL2RGB, d[i]);
    wait_drained();

    // Idling phases: none, sender idle, receiver stalling, both.
    send_random(200);
    send_idle_pct = 78; send_random(150);
    send_idle_pct = 0; stall_pct = 78; send_random(150);
    send_idle_pct = 10; stall_pct = 10; send_random(150);
    send_idle_pct = 0; stall_pct = 0;

    // Hold the receiver off so the pipeline fills and stalls the input.
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      send_random(30);
    join
    // Pause the sender until everything has come back.
    wait_drained();
    send_random(170);

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
